FILE: hdl/clcs_pkg.sv
// ----------------------------------------------------------------------------
// clcs_pkg
// Shared types and constants for the sampled circle line clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package clcs_pkg;

  localparam int COORD_BITS  = 16;
  localparam int RADIUS_BITS = 15;
  localparam int CMP_W       = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam int CFG_W       = CMP_W;
  localparam int SQ_W        = 2 * RADIUS_BITS;

  typedef logic signed [COORD_BITS-1:0]  coord_t;
  typedef logic        [COORD_BITS-1:0]  mag_t;
  typedef logic        [RADIUS_BITS-1:0] rad_t;
  typedef logic        [CFG_W-1:0]       cfg_data_t;
  typedef logic        [1:0]             cfg_idx_t;
  typedef logic        [1:0]             clip_status_t;

  localparam cfg_idx_t REG_CENTER_X = 2'd0;
  localparam cfg_idx_t REG_CENTER_Y = 2'd1;
  localparam cfg_idx_t REG_RADIUS   = 2'd2;

  localparam clip_status_t ST_CLIPPED = 2'd0;
  localparam clip_status_t ST_MISS    = 2'd1;
  localparam clip_status_t ST_ZERO    = 2'd2;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    clip_status_t clip_status;
    coord_t       clip_start_x;
    coord_t       clip_start_y;
    coord_t       clip_end_x;
    coord_t       clip_end_y;
  } out_item_t;

  typedef struct packed {
    logic init;
    logic adv;
    logic load_pt;
  } dda_ctrl_t;

  typedef enum logic [1:0] {
    MOP_IDLE,
    MOP_R2,
    MOP_X,
    MOP_Y
  } mul_op_t;

endpackage

`default_nettype wire

FILE: hdl/circle_line_clip_by_sampling_top.sv
// ----------------------------------------------------------------------------
// circle_line_clip_by_sampling_top
// Clips a segment to a circle by testing evenly spaced sample points.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 centre x, 1 centre y,
//   2 radius) and cfg_data. cfg_ready is always high; writes are meant for
//   idle periods only. Other indexes are ignored.
//   Input: an item transfers on a rising edge with start high and busy low.
//   busy stays high until the result has been produced.
//   Output: out_valid strobes for one cycle with out_item; the receiver
//   cannot stall, so the result must be taken in that cycle.
//   Timing: after the input transfer the block passes through the difference
//   state and then, per sample step, an x-square and a y-square state; the
//   strobe follows the last step (the difference state for a zero-length
//   segment). A new item is accepted in the strobe cycle. Each sample step
//   uses the single squarer for the x offset, then the y offset.
//   Reset: rst_n (synchronous, active low) returns to idle and clears the
//   circle registers to centre 0, radius 0.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_line_clip_by_sampling_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire clcs_pkg::in_item_t   in_item,
  output logic                      out_valid,
  output clcs_pkg::out_item_t       out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire clcs_pkg::cfg_idx_t   cfg_index,
  input  wire clcs_pkg::cfg_data_t  cfg_data
);
  import clcs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIFF,
    S_SQX,
    S_SQY
  } state_t;

  state_t    state_r;
  coord_t    cx_r, cy_r;
  rad_t      rad_r;
  in_item_t  item_r;
  out_item_t out_item_r;
  logic      out_valid_r, out_valid_nxt;

  logic      found_r, found_nxt;
  coord_t    fx_r, fy_r, lx_r, ly_r;
  coord_t    fx_nxt, fy_nxt, lx_nxt, ly_nxt;

  dda_ctrl_t dctl;
  mul_op_t   mop;
  coord_t    px, py;
  logic      zero_len, last, hit;
  logic      accept;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  clcs_dda u_dda (
    .clk      (clk),
    .ctrl     (dctl),
    .x1       (item_r.start_x),
    .y1       (item_r.start_y),
    .x2       (item_r.end_x),
    .y2       (item_r.end_y),
    .px       (px),
    .py       (py),
    .zero_len (zero_len),
    .last     (last)
  );

  clcs_inside u_inside (
    .clk    (clk),
    .op     (mop),
    .cx     (cx_r),
    .cy     (cy_r),
    .radius (rad_r),
    .px     (px),
    .py     (py),
    .hit    (hit)
  );

  always_comb begin
    dctl.init    = (state_r == S_DIFF);
    dctl.adv     = (state_r == S_SQX);
    dctl.load_pt = (state_r == S_SQY);
    unique case (state_r)
      S_DIFF:  mop = MOP_R2;
      S_SQX:   mop = MOP_X;
      S_SQY:   mop = MOP_Y;
      default: mop = MOP_IDLE;
    endcase
    out_valid_nxt = ((state_r == S_DIFF) && zero_len) ||
                    ((state_r == S_SQY) && last);
    found_nxt = found_r;
    fx_nxt    = fx_r;
    fy_nxt    = fy_r;
    lx_nxt    = lx_r;
    ly_nxt    = ly_r;
    if (state_r == S_DIFF) begin
      found_nxt = 1'b0;
    end
    if ((state_r == S_SQY) && hit) begin
      if (!found_r) begin
        fx_nxt = px;
        fy_nxt = py;
      end
      lx_nxt    = px;
      ly_nxt    = py;
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      rad_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER_X: cx_r  <= cfg_data[COORD_BITS-1:0];
        REG_CENTER_Y: cy_r  <= cfg_data[COORD_BITS-1:0];
        REG_RADIUS:   rad_r <= cfg_data[RADIUS_BITS-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      fx_r        <= fx_nxt;
      fy_r        <= fy_nxt;
      lx_r        <= lx_nxt;
      ly_r        <= ly_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_r  <= in_item;
            state_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (zero_len) begin
            out_item_r <= '{clip_status: ST_ZERO, default: '0};
            state_r    <= S_IDLE;
          end else begin
            state_r <= S_SQX;
          end
        end
        S_SQX: begin
          state_r <= S_SQY;
        end
        S_SQY: begin
          if (last) begin
            if (found_nxt) begin
              out_item_r.clip_status  <= ST_CLIPPED;
              out_item_r.clip_start_x <= fx_nxt;
              out_item_r.clip_start_y <= fy_nxt;
              out_item_r.clip_end_x   <= lx_nxt;
              out_item_r.clip_end_y   <= ly_nxt;
            end else begin
              out_item_r <= '{clip_status: ST_MISS, default: '0};
            end
            state_r <= S_IDLE;
          end else begin
            state_r <= S_SQX;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.clip_status != ST_CLIPPED)) |->
      ((out_item.clip_start_x == '0) && (out_item.clip_start_y == '0) &&
       (out_item.clip_end_x == '0) && (out_item.clip_end_y == '0)))
    else $error("non-clipped result carries coordinates");

  a_sq_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQX) |=> (state_r == S_SQY))
    else $error("x square not followed by y square");

endmodule

`default_nettype wire

FILE: hdl/clcs_dda.sv
// ----------------------------------------------------------------------------
// clcs_dda
// Exact rational step generator: holds s*|d| = q*m + r per axis and forms
// the truncated sample point of the current step.
// ----------------------------------------------------------------------------
`default_nettype none

module clcs_dda (
  input  wire logic               clk,
  input  wire clcs_pkg::dda_ctrl_t ctrl,
  input  wire clcs_pkg::coord_t   x1,
  input  wire clcs_pkg::coord_t   y1,
  input  wire clcs_pkg::coord_t   x2,
  input  wire clcs_pkg::coord_t   y2,
  output clcs_pkg::coord_t        px,
  output clcs_pkg::coord_t        py,
  output logic                    zero_len,
  output logic                    last
);
  import clcs_pkg::*;

  localparam int W = COORD_BITS;

  logic signed [W:0] dx, dy;
  mag_t              ax, ay, m;
  logic              nx, ny;

  mag_t              ax_r, ay_r, m_r, s_r;
  logic              nx_r, ny_r;
  logic [W-1:0]      rx_r, ry_r;
  logic [W:0]        qx_r, qy_r;
  coord_t            px_r, py_r;

  logic [W:0]        rx_sum, ry_sum;

  function automatic coord_t trunc_pt(coord_t base, logic neg, logic [W:0] q,
                                      logic [W-1:0] r);
    logic signed [W+1:0] be;
    logic signed [W+1:0] qe;
    logic signed [W+1:0] b;
    be = {{2{base[W-1]}}, base};
    qe = {1'b0, q};
    b  = neg ? (be - qe) : (be + qe);
    if (r != '0) begin
      if (!neg && b[W+1]) begin
        b = b + (W+2)'(1);
      end else if (neg && !b[W+1] && (b != '0)) begin
        b = b - (W+2)'(1);
      end
    end
    return b[W-1:0];
  endfunction

  always_comb begin
    dx = {x2[W-1], x2} - {x1[W-1], x1};
    dy = {y2[W-1], y2} - {y1[W-1], y1};
    nx = dx[W];
    ny = dy[W];
    ax = nx ? W'(-dx) : W'(dx);
    ay = ny ? W'(-dy) : W'(dy);
    m  = (ax > ay) ? ax : ay;
    zero_len = (m == '0);
    rx_sum = {1'b0, rx_r} + {1'b0, ax_r};
    ry_sum = {1'b0, ry_r} + {1'b0, ay_r};
  end

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      ax_r <= ax;
      ay_r <= ay;
      nx_r <= nx;
      ny_r <= ny;
      m_r  <= m;
      rx_r <= '0;
      ry_r <= '0;
      qx_r <= '0;
      qy_r <= '0;
      s_r  <= '0;
      px_r <= x1;
      py_r <= y1;
    end else begin
      if (ctrl.adv) begin
        if (rx_sum >= {1'b0, m_r}) begin
          rx_r <= W'(rx_sum - {1'b0, m_r});
          qx_r <= qx_r + (W+1)'(1);
        end else begin
          rx_r <= W'(rx_sum);
        end
        if (ry_sum >= {1'b0, m_r}) begin
          ry_r <= W'(ry_sum - {1'b0, m_r});
          qy_r <= qy_r + (W+1)'(1);
        end else begin
          ry_r <= W'(ry_sum);
        end
      end
      if (ctrl.load_pt) begin
        px_r <= trunc_pt(x1, nx_r, qx_r, rx_r);
        py_r <= trunc_pt(y1, ny_r, qy_r, ry_r);
        s_r  <= s_r + W'(1);
      end
    end
  end

  assign px   = px_r;
  assign py   = py_r;
  assign last = (s_r == m_r);

endmodule

`default_nettype wire

FILE: hdl/clcs_inside.sv
// ----------------------------------------------------------------------------
// clcs_inside
// Inside test around one shared squarer: radius squared once per item,
// then x and y offsets squared in alternation.
// ----------------------------------------------------------------------------
`default_nettype none

module clcs_inside (
  input  wire logic             clk,
  input  wire clcs_pkg::mul_op_t op,
  input  wire clcs_pkg::coord_t cx,
  input  wire clcs_pkg::coord_t cy,
  input  wire clcs_pkg::rad_t   radius,
  input  wire clcs_pkg::coord_t px,
  input  wire clcs_pkg::coord_t py,
  output logic                  hit
);
  import clcs_pkg::*;

  localparam int W = COORD_BITS;

  logic signed [W:0] ex, ey;
  logic [CMP_W-1:0]  magx, magy, rad_e;
  logic              farx, fary;
  rad_t              mul_a;
  logic [SQ_W-1:0]   prod;
  logic [SQ_W:0]     sum;

  logic [SQ_W-1:0]   r2_r, sqx_r;
  logic              farx_r;

  always_comb begin
    ex    = {px[W-1], px} - {cx[W-1], cx};
    ey    = {py[W-1], py} - {cy[W-1], cy};
    magx  = CMP_W'(ex[W] ? W'(-ex) : W'(ex));
    magy  = CMP_W'(ey[W] ? W'(-ey) : W'(ey));
    rad_e = CMP_W'(radius);
    farx  = magx > rad_e;
    fary  = magy > rad_e;
    case (op)
      MOP_R2:  mul_a = radius;
      MOP_X:   mul_a = magx[RADIUS_BITS-1:0];
      MOP_Y:   mul_a = magy[RADIUS_BITS-1:0];
      default: mul_a = '0;
    endcase
    prod = mul_a * mul_a;
    sum  = {1'b0, sqx_r} + {1'b0, prod};
    hit  = !farx_r && !fary && (sum <= {1'b0, r2_r});
  end

  always_ff @(posedge clk) begin
    if (op == MOP_R2) begin
      r2_r <= prod;
    end
    if (op == MOP_X) begin
      sqx_r  <= prod;
      farx_r <= farx;
    end
  end

endmodule

`default_nettype wire

FILE: verif/clcs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clcs_checker
// Watches the configuration, input and result channels of the sampled circle
// line clipper. Keeps its own copy of the circle registers and works out the
// expected clip result of every accepted segment. Each result strobe is
// compared field by field with the oldest waiting expectation.
// ----------------------------------------------------------------------------
module clcs_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  clcs_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  clcs_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  clcs_pkg::cfg_idx_t  cfg_index,
  input  clcs_pkg::cfg_data_t cfg_data,
  output int                  n_errors,
  output int                  n_pending
);
  import clcs_pkg::*;

  coord_t    ctr_x = '0;
  coord_t    ctr_y = '0;
  rad_t      rad   = '0;
  out_item_t clip_q[$];
  int        err_count  = 0;
  int        pend_count = 0;
  int        result_idx = 0;

  assign n_errors  = err_count;
  assign n_pending = pend_count;

  task automatic report_mismatch(string msg);
    $display("mismatch at result %0d: %s", result_idx, msg);
    err_count++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic longint trunc_step(longint base, bit neg, longint q, longint r);
    longint b;
    if (!neg) begin
      b = base + q;
      if (r != 0 && b < 0) b = b + 1;
    end else begin
      b = base - q;
      if (r != 0 && b > 0) b = b - 1;
    end
    return b;
  endfunction

  function automatic bit in_circle(longint px, longint py);
    longint ex, ey, rr;
    ex = px - longint'(ctr_x);
    ey = py - longint'(ctr_y);
    rr = longint'(rad);
    if (ex < 0) ex = -ex;
    if (ey < 0) ey = -ey;
    if (ex > rr || ey > rr) return 1'b0;
    return (ex * ex + ey * ey) <= rr * rr;
  endfunction

  function automatic out_item_t clip_segment(in_item_t seg);
    longint    x1, y1, dx, dy, ax, ay, m, s;
    longint    qx, rx, qy, ry, px, py, fx, fy, lx, ly;
    bit        nx, ny, found;
    out_item_t res;
    res = '0;
    x1 = longint'($signed(seg.start_x));
    y1 = longint'($signed(seg.start_y));
    dx = longint'($signed(seg.end_x)) - x1;
    dy = longint'($signed(seg.end_y)) - y1;
    nx = dx < 0;
    ny = dy < 0;
    ax = nx ? -dx : dx;
    ay = ny ? -dy : dy;
    m  = (ax > ay) ? ax : ay;
    if (m == 0) begin
      res.clip_status = ST_ZERO;
      return res;
    end
    qx = 0; rx = 0; qy = 0; ry = 0;
    fx = 0; fy = 0; lx = 0; ly = 0;
    found = 1'b0;
    for (s = 0; s <= m; s++) begin
      px = trunc_step(x1, nx, qx, rx);
      py = trunc_step(y1, ny, qy, ry);
      if (in_circle(px, py)) begin
        if (!found) begin
          fx = px;
          fy = py;
          found = 1'b1;
        end
        lx = px;
        ly = py;
      end
      rx += ax;
      if (rx >= m) begin
        rx -= m;
        qx++;
      end
      ry += ay;
      if (ry >= m) begin
        ry -= m;
        qy++;
      end
    end
    if (!found) begin
      res.clip_status = ST_MISS;
      return res;
    end
    res.clip_status  = ST_CLIPPED;
    res.clip_start_x = coord_t'(fx);
    res.clip_start_y = coord_t'(fy);
    res.clip_end_x   = coord_t'(lx);
    res.clip_end_y   = coord_t'(ly);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      ctr_x = '0;
      ctr_y = '0;
      rad   = '0;
      clip_q.delete();
      pend_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER_X: ctr_x = coord_t'(cfg_data);
          REG_CENTER_Y: ctr_y = coord_t'(cfg_data);
          REG_RADIUS:   rad   = rad_t'(cfg_data);
          default: ;
        endcase
      end
      if (out_valid) begin
        if (clip_q.size() == 0) begin
          report_mismatch($sformatf("result with no segment waiting, status %0d",
                                    out_item.clip_status));
        end else begin
          want = clip_q.pop_front();
          check_field("clip_status", out_item.clip_status, want.clip_status);
          check_field("clip_start_x", $signed(out_item.clip_start_x),
                      $signed(want.clip_start_x));
          check_field("clip_start_y", $signed(out_item.clip_start_y),
                      $signed(want.clip_start_y));
          check_field("clip_end_x", $signed(out_item.clip_end_x),
                      $signed(want.clip_end_x));
          check_field("clip_end_y", $signed(out_item.clip_end_y),
                      $signed(want.clip_end_y));
        end
        result_idx++;
      end
      if (start && !busy) clip_q.push_back(clip_segment(in_item));
      pend_count <= clip_q.size();
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sampled circle line clipper. A directed set covers the
// coordinate extremes, zero-length segments, misses, single-sample hits and
// truncation, then random phases each set a new circle and send segments,
// mostly placed around the circle. Start gaps are random with calm stretches.
// Checking is done by clcs_checker.
// ----------------------------------------------------------------------------
module tb;
  import clcs_pkg::*;

  localparam cfg_idx_t REG_UNUSED = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      start     = 1'b0;
  logic      busy;
  in_item_t  in_item   = '0;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = REG_CENTER_X;
  cfg_data_t cfg_data  = '0;
  int        n_errors;
  int        n_pending;
  int        calm_left = 0;

  always #2 clk = ~clk;

  circle_line_clip_by_sampling_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  clcs_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .n_errors  (n_errors),
    .n_pending (n_pending)
  );

  function automatic int draw_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic longint offset(longint n);
    return longint'($urandom_range(0, int'(2 * n))) - n;
  endfunction

  function automatic longint any_coord();
    coord_t c;
    c = coord_t'($urandom);
    return longint'(c);
  endfunction

  function automatic in_item_t random_segment(coord_t cx, coord_t cy, rad_t r);
    longint   span, x1, y1, x2, y2;
    int       kind;
    in_item_t seg;
    span = longint'(r) + 8;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      x1 = longint'(cx) + offset(span);
      y1 = longint'(cy) + offset(span);
      if (kind < 60 && r <= 400) begin
        x2 = longint'(cx) + offset(span);
        y2 = longint'(cy) + offset(span);
      end else if (kind < 60) begin
        x2 = x1 + offset(255);
        y2 = y1 + offset(255);
      end else begin
        x2 = x1 + offset(1023);
        y2 = y1 + offset(1023);
      end
    end else if (kind < 95) begin
      x1 = any_coord();
      y1 = any_coord();
      x2 = x1 + offset(63);
      y2 = y1 + offset(63);
    end else begin
      x1 = (kind < 98) ? longint'(cx) + offset(span) : any_coord();
      y1 = (kind < 98) ? longint'(cy) + offset(span) : any_coord();
      x2 = x1;
      y2 = y1;
    end
    seg.start_x = clamp_coord(x1);
    seg.start_y = clamp_coord(y1);
    seg.end_x   = clamp_coord(x2);
    seg.end_y   = clamp_coord(y2);
    return seg;
  endfunction

  task automatic send_segment(in_item_t seg);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= seg;
    do @(posedge clk); while (busy);
  endtask

  task automatic seg(int x1, int y1, int x2, int y2);
    in_item_t it;
    it.start_x = coord_t'(x1);
    it.start_y = coord_t'(y1);
    it.end_x   = coord_t'(x2);
    it.end_y   = coord_t'(y2);
    send_segment(it);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  task automatic write_circle(int cx, int cy, int r);
    cfg_idx_t  idx [4];
    cfg_data_t val [4];
    int        n;
    idx[0] = REG_CENTER_X;
    val[0] = cfg_data_t'(coord_t'(cx));
    idx[1] = REG_CENTER_Y;
    val[1] = cfg_data_t'(coord_t'(cy));
    idx[2] = REG_RADIUS;
    val[2] = cfg_data_t'(rad_t'(r));
    val[2][CFG_W-1] = $urandom_range(0, 1);
    n = 3;
    if ($urandom_range(0, 1)) begin
      idx[3] = REG_UNUSED;
      val[3] = cfg_data_t'($urandom);
      n = 4;
    end
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    coord_t cx, cy;
    rad_t   r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset circle: centre 0, radius 0
    seg(-2, 0, 2, 0);
    seg(7, 7, 7, 7);
    seg(10, 10, 20, -5);
    settle();

    write_circle(0, 0, 100);
    seg(-200, 0, 200, 0);
    seg(0, -150, 0, 150);
    seg(150, 150, -150, -150);
    seg(3, -7, -5, 2);
    seg(50, 50, 500, 10);
    seg(-300, -300, -200, -300);
    seg(-1, -1, -1, -1);
    seg(100, 0, 100, 5);
    seg(71, 71, 72, 72);
    settle();

    write_circle(-32768, 32767, 32767);
    seg(-32768, -32768, 32767, 32767);
    seg(32767, -32768, 32767, -32768);
    seg(-32768, 32767, -32768, 32767);
    seg(-32768, 0, -32768, 32767);
    seg(-1, -1, 0, 0);
    settle();

    write_circle(32767, -32768, 0);
    seg(32767, -32768, 32700, -32700);
    seg(32760, -32768, 32767, -32768);
    seg(32767, -32767, 32767, -32767);
    seg(0, 0, 5, 3);
    seg(32767, 32767, -32768, -32768);
    settle();

    write_circle(0, 0, 32767);
    seg(-32768, -32768, -32000, -32000);
    seg(-32767, 0, -32760, 0);
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 3))
        0: begin
          cx = '0;
          cy = '0;
        end
        1: begin
          cx = coord_t'($urandom);
          cy = coord_t'($urandom);
        end
        2: begin
          cx = $urandom_range(0, 1) ? coord_t'(32767) : coord_t'(-32768);
          cy = $urandom_range(0, 1) ? coord_t'(32767) : coord_t'(-32768);
        end
        default: begin
          cx = clamp_coord(offset(1000));
          cy = clamp_coord(offset(1000));
        end
      endcase
      case ($urandom_range(0, 5))
        0:       r = '0;
        1:       r = rad_t'($urandom_range(1, 15));
        2, 3:    r = rad_t'($urandom_range(16, 400));
        4:       r = rad_t'($urandom_range(401, 32767));
        default: r = rad_t'($urandom_range(0, 1) ? 32767 : $urandom_range(16, 200));
      endcase
      write_circle(int'(cx), int'(cy), int'(r));
      for (int i = 0; i < 58; i++) send_segment(random_segment(cx, cy, r));
      settle();
    end

    repeat (20) @(posedge clk);
    if (n_errors == 0 && n_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: files.f
hdl/clcs_pkg.sv
hdl/clcs_dda.sv
hdl/clcs_inside.sv
hdl/circle_line_clip_by_sampling_top.sv
verif/clcs_checker.sv
verif/tb.sv
